>>> src/ds402_enable_fault_reset_sequencer_core_defines.svh
// Assertion macros for the drive enable and fault-reset sequencer.
// Included by the top level; no other dependencies.
`ifndef DS402_ENABLE_FAULT_RESET_SEQUENCER_CORE_DEFINES_SVH
`define DS402_ENABLE_FAULT_RESET_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define DS402_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ds402 sequencer: same-cycle check failed");
`define DS402_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ds402 sequencer: next-cycle check failed");
`else
`define DS402_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DS402_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> src/ds402_pkg.sv
// Shared types, control word codes and status decode for the sequencer.
// No dependencies.
`default_nettype none

package ds402_pkg;

    typedef enum logic [3:0] {
        ST_NOT_READY          = 4'd0,
        ST_SWITCH_ON_DISABLED = 4'd1,
        ST_READY              = 4'd2,
        ST_SWITCHED_ON        = 4'd3,
        ST_ENABLED            = 4'd4,
        ST_QUICK_STOP         = 4'd5,
        ST_FAULT_REACTION     = 4'd6,
        ST_FAULT              = 4'd7,
        ST_UNKNOWN            = 4'd8
    } drive_state_t;

    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_LOW_BEFORE = 2'd1,
        PH_PULSE      = 2'd2,
        PH_LOW_AFTER  = 2'd3
    } phase_t;

    localparam logic [15:0] CW_DISABLE_VOLTAGE  = 16'h0000;
    localparam logic [15:0] CW_SHUTDOWN         = 16'h0006;
    localparam logic [15:0] CW_SWITCH_ON        = 16'h0007;
    localparam logic [15:0] CW_ENABLE_OPERATION = 16'h000F;
    localparam logic [15:0] CW_FAULT_RESET      = 16'h0080;

    // Only bits 6:0 of the status word take part in the decode.
    localparam int unsigned SW_DECODE_BITS = 7;

    localparam logic [SW_DECODE_BITS-1:0] MASK_4F = 7'h4F;
    localparam logic [SW_DECODE_BITS-1:0] MASK_6F = 7'h6F;

    function automatic drive_state_t decode_state(input logic [SW_DECODE_BITS-1:0] sw);
        logic [SW_DECODE_BITS-1:0] m4f;
        logic [SW_DECODE_BITS-1:0] m6f;
        drive_state_t              st;
        m4f = sw & MASK_4F;
        m6f = sw & MASK_6F;
        // First match wins.
        if (m4f == 7'h00)
            st = ST_NOT_READY;
        else if (m4f == 7'h40)
            st = ST_SWITCH_ON_DISABLED;
        else if (m6f == 7'h21)
            st = ST_READY;
        else if (m6f == 7'h23)
            st = ST_SWITCHED_ON;
        else if (m6f == 7'h27)
            st = ST_ENABLED;
        else if (m6f == 7'h07)
            st = ST_QUICK_STOP;
        else if (m4f == 7'h0F)
            st = ST_FAULT_REACTION;
        else if (m4f == 7'h08)
            st = ST_FAULT;
        else
            st = ST_UNKNOWN;
        return st;
    endfunction

    function automatic logic [15:0] enable_word(input drive_state_t st);
        logic [15:0] cw;
        case (st)
            ST_SWITCH_ON_DISABLED: cw = CW_SHUTDOWN;
            ST_READY:              cw = CW_SWITCH_ON;
            ST_SWITCHED_ON:        cw = CW_ENABLE_OPERATION;
            ST_ENABLED:            cw = CW_ENABLE_OPERATION;
            ST_QUICK_STOP:         cw = CW_ENABLE_OPERATION;
            default:               cw = CW_DISABLE_VOLTAGE;
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

>>> src/ds402_enable_fault_reset_sequencer_core.sv
// Path: an input beat goes through the input register, then the result register.
// Throughput: one beat per cycle while out_ready is high; decode and phase update are combinational.
// rst_n (async, active low) empties both stages and returns the reset phase to idle.
// The phase register advances only as an item moves into the result register,
// so results follow input order under any stall on either side.
`default_nettype none

`include "ds402_enable_fault_reset_sequencer_core_defines.svh"

module ds402_enable_fault_reset_sequencer_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] drive_status,
    input  wire logic        reset_request,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [15:0]      control_word,
    output logic [3:0]       drive_state,
    output logic             reset_pending
);

    localparam int unsigned SwBits = ds402_pkg::SW_DECODE_BITS;

    // Input stage
    logic                    s1_valid_reg;
    logic [SwBits-1:0]       s1_status_reg;
    logic                    s1_req_reg;
    logic                    s1_adv;

    // Sequencer state
    ds402_pkg::phase_t       phase_reg;
    ds402_pkg::phase_t       phase_next;
    ds402_pkg::phase_t       phase_req;
    ds402_pkg::drive_state_t s1_state;
    logic [15:0]             cw_next;

    // Result stage
    logic                    out_valid_reg;
    logic [15:0]             control_word_reg;
    ds402_pkg::drive_state_t drive_state_reg;
    logic                    reset_pending_reg;

    // Check terms
    logic                    out_fault;
    logic                    out_pulse;
    logic                    s1_pulse_fault;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk) begin
        if (in_valid && in_ready)
        begin
            s1_status_reg <= drive_status[SwBits-1:0];
            s1_req_reg    <= reset_request;
        end
    end

    assign s1_state = ds402_pkg::decode_state(s1_status_reg);

    // A request only starts a sequence from idle.
    assign phase_req = (s1_req_reg && phase_reg == ds402_pkg::PH_IDLE)
                       ? ds402_pkg::PH_LOW_BEFORE : phase_reg;

    // Next phase
    always_comb begin
        if (s1_state != ds402_pkg::ST_FAULT)
        begin
            phase_next = ds402_pkg::PH_IDLE;
        end
        else
        begin
            case (phase_req)
                ds402_pkg::PH_LOW_BEFORE: phase_next = ds402_pkg::PH_PULSE;
                ds402_pkg::PH_PULSE:      phase_next = ds402_pkg::PH_LOW_AFTER;
                default:                  phase_next = ds402_pkg::PH_IDLE;
            endcase
        end
    end

    // Control word
    always_comb begin
        if (s1_state != ds402_pkg::ST_FAULT)
        begin
            cw_next = ds402_pkg::enable_word(s1_state);
        end
        else
        begin
            case (phase_req)
                ds402_pkg::PH_PULSE: cw_next = ds402_pkg::CW_FAULT_RESET;
                default:             cw_next = ds402_pkg::CW_DISABLE_VOLTAGE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            phase_reg     <= ds402_pkg::PH_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_adv)
            begin
                phase_reg     <= phase_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (s1_adv)
        begin
            control_word_reg  <= cw_next;
            drive_state_reg   <= s1_state;
            reset_pending_reg <= (phase_next != ds402_pkg::PH_IDLE);
        end
    end

    assign out_valid     = out_valid_reg;
    assign control_word  = control_word_reg;
    assign drive_state   = drive_state_reg;
    assign reset_pending = reset_pending_reg;

    assign out_fault      = (drive_state_reg == ds402_pkg::ST_FAULT);
    assign out_pulse      = (control_word_reg == ds402_pkg::CW_FAULT_RESET);
    assign s1_pulse_fault = (phase_reg == ds402_pkg::PH_PULSE)
                            && (s1_state == ds402_pkg::ST_FAULT);

    `DS402_ASSERT_IMP(a_pending_only_in_fault, clk, rst_n, out_valid && reset_pending, out_fault)
    `DS402_ASSERT_IMP(a_pulse_in_sequence, clk, rst_n, out_valid && out_pulse, reset_pending && out_fault)
    `DS402_ASSERT_NXT(a_pulse_follows_phase, clk, rst_n, s1_adv && s1_pulse_fault, out_valid && out_pulse)

endmodule

`default_nettype wire
